/* hw/rtl/lrgd_pkg.sv */
// ----------------------------------------------------------------------------
// lrgd_pkg
// shared types and codes for the gradient descent line fitter
// ----------------------------------------------------------------------------
package lrgd_pkg;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PREDICT = 1'b1;

  localparam logic KIND_TRAIN = 1'b0;
  localparam logic KIND_PRED  = 1'b1;

  localparam logic [1:0] REG_LEARNING_RATE   = 2'd0;
  localparam logic [1:0] REG_ERROR_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_ITERATION_CAP   = 2'd2;

  localparam logic [23:0] LR_RESET  = 24'd16777;
  localparam logic [31:0] THR_RESET = 32'd6554;
  localparam logic [19:0] CAP_RESET = 20'd65536;

  localparam logic [1:0] DIV_ERR = 2'd0;
  localparam logic [1:0] DIV_GA  = 2'd1;
  localparam logic [1:0] DIV_GB  = 2'd2;

  typedef struct packed {
    logic        clr_coef;
    logic        clr_acc;
    logic        load_px;
    logic        use_px;
    logic        mul1;
    logic        res;
    logic        mul2;
    logic        acc;
    logic        div_start;
    logic [1:0]  div_sel;
    logic        take_err;
    logic        take_ga;
    logic        take_gb;
    logic        stepm;
    logic        upd;
    logic        out_load;
    logic        out_kind;
    logic        out_conv;
    logic [19:0] iters;
  } lrgd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic err_low;
  } lrgd_stat_t;

endpackage

/* hw/rtl/lrgd_ram.sv */
// ----------------------------------------------------------------------------
// lrgd_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module lrgd_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                         wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/lrgd_div.sv */
// ----------------------------------------------------------------------------
// lrgd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lrgd_div #(
  parameter int NW = 64,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int KW = $clog2(NW + 1);

  logic          busy;
  logic [KW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_t;
  logic          qbit;

  assign rem_t = {rem, quot[NW-1]};
  assign qbit  = (rem_t >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= KW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[NW-2:0], qbit};
      rem  <= qbit ? DW'(rem_t - {1'b0, den}) : rem_t[DW-1:0];
    end
  end

endmodule

/* hw/rtl/lrgd_datapath.sv */
// ----------------------------------------------------------------------------
// lrgd_datapath
// line evaluation, error and gradient sums, division and coefficient update
// ----------------------------------------------------------------------------
module lrgd_datapath #(
  parameter int CW = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  lrgd_pkg::lrgd_cmd_t  cmd,
  output lrgd_pkg::lrgd_stat_t stat,
  input  logic [CW-1:0]      n,
  input  logic [31:0]        x_in,
  input  logic [31:0]        ram_x,
  input  logic [31:0]        ram_y,
  output logic               o_kind,
  output logic [31:0]        o_slope,
  output logic [31:0]        o_intercept,
  output logic [47:0]        o_mean_error,
  output logic [19:0]        o_iters,
  output logic               o_conv,
  output logic [31:0]        o_pred
);

  import lrgd_pkg::*;

  localparam int SAW = 49 + CW;
  localparam int SBW = 32 + CW;
  localparam int DVW = SAW + 1;
  localparam logic [47:0] ERR_MAX = '1;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v[50:31] == {20{v[50]}}) begin
      return v[31:0];
    end
    return v[50] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [38:0] sat39(input logic signed [DVW-1:0] v);
    if (v[DVW-1:38] == {(DVW-38){v[DVW-1]}}) begin
      return v[38:0];
    end
    return v[DVW-1] ? {1'b1, 38'd0} : {1'b0, {38{1'b1}}};
  endfunction

  logic [23:0] lr;
  logic [31:0] thr;

  logic signed [31:0] a, b, px, xq, yq, rs;
  logic signed [63:0] p, xr;
  logic signed [50:0] r;
  logic signed [31:0] pred;
  logic [63:0]        sq;
  logic               big;
  logic [47:0]        errsum, e;
  logic signed [SAW-1:0] sa;
  logic signed [SBW-1:0] sb;
  logic signed [38:0] ga, gb;
  logic signed [43:0] ph_a, ph_b;
  logic [43:0]        pl_a, pl_b;
  logic               div_neg;

  logic signed [31:0] xs;
  logic signed [63:0] p_rnd, xr_rnd, prod_a, prod_b, pr_a, pr_b;
  logic signed [49:0] line;
  logic [50:0]        rmag;
  logic [47:0]        term;
  logic [48:0]        esum;
  logic signed [DVW-1:0] n2a, n2b, qs;
  logic [DVW-1:0]     div_num, quot;
  logic               div_sign;
  logic               div_done;
  logic signed [39:0] step_a, step_b;

  assign xs     = cmd.use_px ? px : $signed(ram_x);
  assign p_rnd  = p + 64'sd32768;
  assign line   = 50'($signed(p_rnd[63:16])) + 50'(b);
  assign rmag   = r[50] ? 51'(-r) : 51'(r);
  assign term   = big ? ERR_MAX : sq[63:16];
  assign esum   = {1'b0, errsum} + {1'b0, term};
  assign xr_rnd = xr + 64'sd32768;
  assign n2a    = -(DVW'(sa) <<< 1);
  assign n2b    = -(DVW'(sb) <<< 1);
  assign qs     = div_neg ? -$signed(quot) : $signed(quot);
  assign prod_a = (64'(ph_a) <<< 20) + $signed(64'(pl_a));
  assign prod_b = (64'(ph_b) <<< 20) + $signed(64'(pl_b));
  assign pr_a   = prod_a + 64'sd8388608;
  assign pr_b   = prod_b + 64'sd8388608;
  assign step_a = pr_a[63:24];
  assign step_b = pr_b[63:24];

  always_comb begin
    div_num  = DVW'(errsum);
    div_sign = 1'b0;
    case (cmd.div_sel)
      DIV_GA: begin
        div_sign = n2a[DVW-1];
        div_num  = n2a[DVW-1] ? DVW'(-n2a) : DVW'(n2a);
      end
      DIV_GB: begin
        div_sign = n2b[DVW-1];
        div_num  = n2b[DVW-1] ? DVW'(-n2b) : DVW'(n2b);
      end
      default: begin
        div_num  = DVW'(errsum);
        div_sign = 1'b0;
      end
    endcase
  end

  lrgd_div #(.NW(DVW), .DW(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (n),
    .done  (div_done),
    .quot  (quot)
  );

  assign stat.div_done = div_done;
  assign stat.err_low  = (e < 48'(thr));

  always_ff @(posedge clk) begin
    if (rst) begin
      lr  <= LR_RESET;
      thr <= THR_RESET;
      a   <= '0;
      b   <= '0;
    end else begin
      if (cfg_wen && cfg_index == REG_LEARNING_RATE) begin
        lr <= cfg_data[23:0];
      end
      if (cfg_wen && cfg_index == REG_ERROR_THRESHOLD) begin
        thr <= cfg_data;
      end
      if (cmd.clr_coef) begin
        a <= '0;
        b <= '0;
      end else if (cmd.upd) begin
        a <= sat32(51'(a) - 51'(step_a));
        b <= sat32(51'(b) - 51'(step_b));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_px) begin
      px <= x_in;
    end
    if (cmd.mul1) begin
      p  <= a * xs;
      xq <= ram_x;
      yq <= ram_y;
    end
    if (cmd.res) begin
      r    <= 51'(yq) - 51'(line);
      pred <= sat32(51'(line));
    end
    if (cmd.mul2) begin
      sq  <= rmag[31:0] * rmag[31:0];
      big <= |rmag[50:32];
      xr  <= xq * sat32(r);
      rs  <= sat32(r);
    end
    if (cmd.clr_acc) begin
      errsum <= '0;
      sa     <= '0;
      sb     <= '0;
    end else if (cmd.acc) begin
      errsum <= esum[48] ? ERR_MAX : esum[47:0];
      sa     <= sa + SAW'($signed(xr_rnd[63:16]));
      sb     <= sb + SBW'(rs);
    end
    if (cmd.div_start) begin
      div_neg <= div_sign;
    end
    if (cmd.take_err) begin
      e <= quot[47:0];
    end
    if (cmd.take_ga) begin
      ga <= sat39(qs);
    end
    if (cmd.take_gb) begin
      gb <= sat39(qs);
    end
    if (cmd.stepm) begin
      ph_a <= $signed({1'b0, lr}) * $signed(ga[38:20]);
      ph_b <= $signed({1'b0, lr}) * $signed(gb[38:20]);
      pl_a <= lr * ga[19:0];
      pl_b <= lr * gb[19:0];
    end
    if (cmd.out_load) begin
      o_kind <= cmd.out_kind;
      if (cmd.out_kind == KIND_PRED) begin
        o_slope      <= '0;
        o_intercept  <= '0;
        o_mean_error <= '0;
        o_iters      <= '0;
        o_conv       <= 1'b0;
        o_pred       <= pred;
      end else begin
        o_slope      <= a;
        o_intercept  <= b;
        o_mean_error <= e;
        o_iters      <= cmd.iters;
        o_conv       <= cmd.out_conv;
        o_pred       <= '0;
      end
    end
  end

endmodule

/* hw/rtl/lrgd_ctrl.sv */
// ----------------------------------------------------------------------------
// lrgd_ctrl
// sequencer for loading, training iterations, prediction and output
// ----------------------------------------------------------------------------
module lrgd_ctrl #(
  parameter int MAX_SAMPLES = 32,
  parameter int CW = 6,
  parameter int AW = 5
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               s_tuser,
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [AW-1:0]      ram_raddr,
  output logic [CW-1:0]      n,
  output lrgd_pkg::lrgd_cmd_t  cmd,
  input  lrgd_pkg::lrgd_stat_t stat
);

  import lrgd_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_RD    = 5'd1;
  localparam logic [4:0] S_MUL1  = 5'd2;
  localparam logic [4:0] S_RES   = 5'd3;
  localparam logic [4:0] S_MUL2  = 5'd4;
  localparam logic [4:0] S_ACC   = 5'd5;
  localparam logic [4:0] S_DIVE  = 5'd6;
  localparam logic [4:0] S_WDIVE = 5'd7;
  localparam logic [4:0] S_CHK   = 5'd8;
  localparam logic [4:0] S_DIVA  = 5'd9;
  localparam logic [4:0] S_WDIVA = 5'd10;
  localparam logic [4:0] S_DIVB  = 5'd11;
  localparam logic [4:0] S_WDIVB = 5'd12;
  localparam logic [4:0] S_STEPM = 5'd13;
  localparam logic [4:0] S_UPD   = 5'd14;
  localparam logic [4:0] S_PMUL  = 5'd15;
  localparam logic [4:0] S_PRES  = 5'd16;
  localparam logic [4:0] S_OUTT  = 5'd17;
  localparam logic [4:0] S_OUTP  = 5'd18;

  logic [4:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  logic [19:0]   k, k_next;
  logic [19:0]   cap;
  logic          conv, conv_next;
  logic          slot;

  assign s_tready  = (state == S_IDLE);
  assign ram_waddr = count[AW-1:0];
  assign ram_raddr = idx;
  assign n         = count;
  assign slot      = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    count_next = count;
    idx_next   = idx;
    k_next     = k;
    conv_next  = conv;
    ram_we     = 1'b0;
    cmd        = '0;
    cmd.iters  = k;
    cmd.out_conv = conv;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == CMD_PREDICT) begin
            cmd.load_px = 1'b1;
            state_next  = S_PMUL;
          end else begin
            if (count < CW'(MAX_SAMPLES)) begin
              ram_we     = 1'b1;
              count_next = count + 1'b1;
            end
            if (s_tlast) begin
              cmd.clr_coef = 1'b1;
              cmd.clr_acc  = 1'b1;
              idx_next     = '0;
              k_next       = '0;
              state_next   = S_RD;
            end
          end
        end
      end
      S_RD:   state_next = S_MUL1;
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_RES;
      end
      S_RES: begin
        cmd.res    = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (idx == AW'(count - 1'b1)) begin
          state_next = S_DIVE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_RD;
        end
      end
      S_DIVE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ERR;
        state_next    = S_WDIVE;
      end
      S_WDIVE: begin
        if (stat.div_done) begin
          cmd.take_err = 1'b1;
          state_next   = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.err_low) begin
          conv_next  = 1'b1;
          state_next = S_OUTT;
        end else if (k >= cap) begin
          conv_next  = 1'b0;
          state_next = S_OUTT;
        end else begin
          state_next = S_DIVA;
        end
      end
      S_DIVA: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_GA;
        state_next    = S_WDIVA;
      end
      S_WDIVA: begin
        if (stat.div_done) begin
          cmd.take_ga = 1'b1;
          state_next  = S_DIVB;
        end
      end
      S_DIVB: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_GB;
        state_next    = S_WDIVB;
      end
      S_WDIVB: begin
        if (stat.div_done) begin
          cmd.take_gb = 1'b1;
          state_next  = S_STEPM;
        end
      end
      S_STEPM: begin
        cmd.stepm  = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd     = 1'b1;
        cmd.clr_acc = 1'b1;
        k_next      = k + 1'b1;
        idx_next    = '0;
        state_next  = S_RD;
      end
      S_PMUL: begin
        cmd.mul1   = 1'b1;
        cmd.use_px = 1'b1;
        state_next = S_PRES;
      end
      S_PRES: begin
        cmd.res    = 1'b1;
        state_next = S_OUTP;
      end
      S_OUTT: begin
        if (slot) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_TRAIN;
          count_next   = '0;
          state_next   = S_IDLE;
        end
      end
      S_OUTP: begin
        if (slot) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_PRED;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      idx      <= '0;
      k        <= '0;
      conv     <= 1'b0;
      cap      <= CAP_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      k     <= k_next;
      conv  <= conv_next;
      if (cfg_wen && cfg_index == REG_ITERATION_CAP) begin
        cap <= cfg_data[19:0];
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/linear_regression_gd_trainer.sv */
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer
// fits y = a*x + b to a stored sample set by batch gradient descent
// ----------------------------------------------------------------------------
// input words: tuser selects load (0) or predict (1), tdata carries x and y,
// tlast on a load closes the set and starts training from a = b = 0.
// a load gives no output word; loads past MAX_SAMPLES are dropped.
// training walks the stored samples once per iteration, each sample
// passing through a read, the line product, the residual, the square and
// gradient products and the accumulation, then a bit-serial divider forms
// the mean error; a check follows and, when the iteration goes on, two more
// divisions for the gradients, the step products and the update.
// the run ends on the error threshold or the iteration cap with one report
// word.
// predict takes x into a register, then forms the product and the line
// value with the current coefficients and loads its output word once the
// output register is free.
// the output sits in a register; while the receiver stalls a finished word
// waits there and loads are still taken, the next result waits for it.
// reset clears the sample set and the coefficients and restores the
// register defaults; the sample memories are not cleared.
// ----------------------------------------------------------------------------
module linear_regression_gd_trainer #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [63:0]  s_tdata,   // x_value, y_value
  input  logic         s_tuser,   // cmd
  input  logic         s_tlast,   // last_sample
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [167:0] m_tdata,   // slope, intercept, mean_error, iterations_used,
                                  // converged, prediction, zero pad
  output logic         m_tuser,   // report_kind
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  import lrgd_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  lrgd_cmd_t     cmd;
  lrgd_stat_t    stat;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] n;
  logic [31:0]   ram_x, ram_y;
  logic          o_kind, o_conv;
  logic [31:0]   o_slope, o_intercept, o_pred;
  logic [47:0]   o_mean_error;
  logic [19:0]   o_iters;

  lrgd_ram #(.W(32), .D(MAX_SAMPLES)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata[31:0]),
    .raddr (ram_raddr),
    .rdata (ram_x)
  );

  lrgd_ram #(.W(32), .D(MAX_SAMPLES)) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata[63:32]),
    .raddr (ram_raddr),
    .rdata (ram_y)
  );

  lrgd_ctrl #(.MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_raddr (ram_raddr),
    .n         (n),
    .cmd       (cmd),
    .stat      (stat)
  );

  lrgd_datapath #(.CW(CW)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .n            (n),
    .x_in         (s_tdata[31:0]),
    .ram_x        (ram_x),
    .ram_y        (ram_y),
    .o_kind       (o_kind),
    .o_slope      (o_slope),
    .o_intercept  (o_intercept),
    .o_mean_error (o_mean_error),
    .o_iters      (o_iters),
    .o_conv       (o_conv),
    .o_pred       (o_pred)
  );

  assign m_tuser = o_kind;
  assign m_tdata = {3'b000, o_pred, o_conv, o_iters, o_mean_error, o_intercept, o_slope};

endmodule
